// ===== design/rle_pkg.sv =====
package rle_pkg;

	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	localparam logic [3:0] MAX_RUN = 4'd9;

	// Tuple queue geometry.
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	// Character positions within one tuple.
	localparam logic [2:0] POS_OPEN  = 3'd0;
	localparam logic [2:0] POS_SYM   = 3'd1;
	localparam logic [2:0] POS_COMMA = 3'd2;
	localparam logic [2:0] POS_DIGIT = 3'd3;
	localparam logic [2:0] POS_CLOSE = 3'd4;

	typedef struct packed {
		logic [7:0] sym;
		logic [3:0] len;
		logic       last;
	} tuple_t;

	// Up to two tuples written per beat: first a, then b.
	typedef struct packed {
		logic [1:0] cnt;
		tuple_t     a;
		tuple_t     b;
	} push_t;

	typedef struct packed {
		logic   valid;
		tuple_t entry;
	} head_t;

endpackage

// ===== design/rle_in_if.sv =====
interface rle_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] symbol;
	logic       is_final;

	modport source (output valid, output symbol, output is_final, input ready);
	modport sink   (input valid, input symbol, input is_final, output ready);
endinterface

// ===== design/rle_out_if.sv =====
interface rle_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       end_of_text;

	modport source (output valid, output out_char, output end_of_text, input ready);
	modport sink   (input valid, input out_char, input end_of_text, output ready);
endinterface

// ===== design/rle_front.sv =====
module rle_front
	import rle_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	rle_in_if.sink    raw,
	input  logic      room_two,
	output push_t     push
);

	logic [7:0] run_symbol_q;
	logic [3:0] run_length_q;
	logic       run_open_q;

	logic       accept;
	logic       extend;
	logic       close_old;
	tuple_t     old_t;
	tuple_t     new_t;
	logic [3:0] next_len;

	assign raw.ready = room_two;
	assign accept    = raw.valid && raw.ready;

	assign extend    = run_open_q && (raw.symbol == run_symbol_q) && (run_length_q < MAX_RUN);
	assign close_old = run_open_q && !extend;
	assign next_len  = extend ? (run_length_q + 4'd1) : 4'd1;

	always_comb begin
		old_t.sym  = run_symbol_q;
		old_t.len  = run_length_q;
		old_t.last = 1'b0;
		new_t.sym  = raw.symbol;
		new_t.len  = next_len;
		new_t.last = 1'b1;

		push.a   = old_t;
		push.b   = new_t;
		push.cnt = 2'd0;
		if (accept) begin
			if (close_old && raw.is_final) begin
				push.cnt = 2'd2;
			end else if (raw.is_final) begin
				push.cnt = 2'd1;
				push.a   = new_t;
			end else if (close_old) begin
				push.cnt = 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_symbol_q <= 8'd0;
			run_length_q <= 4'd0;
			run_open_q   <= 1'b0;
		end else if (accept) begin
			if (raw.is_final) begin
				run_symbol_q <= 8'd0;
				run_length_q <= 4'd0;
				run_open_q   <= 1'b0;
			end else begin
				run_symbol_q <= raw.symbol;
				run_length_q <= next_len;
				run_open_q   <= 1'b1;
			end
		end
	end

endmodule

// ===== design/rle_queue.sv =====
module rle_queue
	import rle_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	input  logic  pop,
	output head_t head,
	output logic  room_two
);

	tuple_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic [QPTR_W-1:0]   wr_ptr_b;
	logic                do_pop;

	assign wr_ptr_b    = wr_ptr_q + QPTR_W'(1);
	assign do_pop      = pop && (count_q != '0);
	assign head.valid  = (count_q != '0);
	assign head.entry  = mem_q[rd_ptr_q];
	assign room_two    = (count_q <= QCNT_W'(QDEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push.a;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_ptr_b] <= push.b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push.cnt);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push.cnt) - QCNT_W'(do_pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("tuple queue count above depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt != 2'd0) |-> (count_q <= QCNT_W'(QDEPTH - 2)))
		else $error("tuple written without room");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt == 2'd0 && !do_pop) |=> $stable(count_q))
		else $error("tuple queue count moved while idle");

endmodule

// ===== design/rle_back.sv =====
module rle_back
	import rle_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  head_t      head,
	output logic       pop,
	rle_out_if.source  coded
);

	tuple_t     cur_q;
	logic [2:0] pos_q;
	logic       busy_q;
	logic       done_char;

	assign done_char = busy_q && coded.ready && (pos_q == POS_CLOSE);
	assign pop       = head.valid && (!busy_q || done_char);

	assign coded.valid       = busy_q;
	assign coded.end_of_text = cur_q.last && (pos_q == POS_CLOSE);

	always_comb begin
		unique case (pos_q)
			POS_OPEN:  coded.out_char = CH_OPEN;
			POS_SYM:   coded.out_char = cur_q.sym;
			POS_COMMA: coded.out_char = CH_COMMA;
			POS_DIGIT: coded.out_char = CH_ZERO + {4'd0, cur_q.len};
			default:   coded.out_char = CH_CLOSE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= POS_OPEN;
			busy_q <= 1'b0;
		end else if (pop) begin
			pos_q  <= POS_OPEN;
			busy_q <= 1'b1;
		end else if (done_char) begin
			pos_q  <= POS_OPEN;
			busy_q <= 1'b0;
		end else if (busy_q && coded.ready) begin
			pos_q <= pos_q + 3'd1;
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_CLOSE)
		else $error("character position out of range");

	a_eot_on_close: assert property (@(posedge clk) disable iff (!arst_n)
		(coded.valid && coded.end_of_text) |-> (coded.out_char == CH_CLOSE))
		else $error("end of text away from closing parenthesis");

	a_pop_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (!busy_q || done_char))
		else $error("tuple taken while one is still being sent");

endmodule

// ===== design/rle_ascii_tuple_encoder_core.sv =====
// Run-length encoder that turns a byte stream into ASCII tuple text. Each run
// of equal bytes leaves as the five characters '(', symbol, ',', count digit,
// ')'; a run is closed at nine bytes so the count is always one digit, and the
// beat that carries is_final closes the open run and flags its ')' with
// end_of_text. The raw side takes one byte per cycle whenever the internal
// tuple queue has two free slots, so runs of repeated bytes stream in at full
// speed. The coded side sends one character per beat, so every closed run
// occupies it for five characters. A line of all-different bytes is therefore
// limited by the output serialiser, while a line of nine-byte runs is limited
// by the raw side at one byte per cycle, as the five characters of each run
// leave while the next nine bytes come in. The byte that closes a run writes
// its tuple into the queue, and the back then loads that tuple from the queue
// head before offering its first character.
// No clearing pass is needed after reset.
module rle_ascii_tuple_encoder_core
	import rle_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	rle_in_if.sink    raw,
	rle_out_if.source coded
);

	// The front tracks the open run and turns each beat into zero, one or two
	// finished tuples; a beat that both breaks a run and ends the line yields
	// the old run followed by the final one.
	push_t push;
	logic  room_two;

	// The queue decouples the run tracker from the character serialiser.
	head_t head;
	logic  pop;

	rle_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.raw      (raw),
		.room_two (room_two),
		.push     (push)
	);

	rle_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.pop      (pop),
		.head     (head),
		.room_two (room_two)
	);

	// The back takes the next tuple in the same cycle as the last character
	// of the current one is taken, so tuples follow each other without gaps.
	rle_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.coded  (coded)
	);

endmodule

// ===== verif/rle_ascii_tuple_encoder_core_tb.sv =====
`timescale 1ns / 1ps

module rle_ascii_tuple_encoder_core_tb;
	import rle_pkg::*;

	// One raw byte waiting to be sent. When drain_first is set, the sender holds
	// off until every character that is already predicted has left the block.
	typedef struct {
		logic [7:0] symbol;
		logic       is_final;
		logic       drain_first;
	} raw_byte_t;

	// One character of tuple text that the block should produce.
	typedef struct {
		logic [7:0] out_char;
		logic       end_of_text;
	} coded_char_t;

	localparam int unsigned STALL_LIMIT  = 2000;
	localparam int unsigned SETTLE_TIME  = 20;
	localparam int unsigned RANDOM_BYTES = 330;

	logic clk;
	logic arst_n;

	rle_in_if  raw ();
	rle_out_if coded ();

	rle_ascii_tuple_encoder_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.raw    (raw),
		.coded  (coded)
	);

	raw_byte_t   byte_q[$];
	coded_char_t char_q[$];

	// Our own copy of the encoder state: the open run and whether one is open.
	logic [7:0] run_sym;
	logic [3:0] run_len;
	logic       run_open;

	int unsigned bytes_sent;
	int unsigned errors;
	int unsigned quiet_cycles;
	logic        calm;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Append the five characters of one tuple to the expected text. Only the
	// closing bracket of a tuple flushed by a final byte carries end_of_text.
	task automatic queue_tuple(input logic [7:0] sym, input logic [3:0] len,
			input logic last);
		coded_char_t c;
		c.end_of_text = 1'b0;
		c.out_char = CH_OPEN;
		char_q.push_back(c);
		c.out_char = sym;
		char_q.push_back(c);
		c.out_char = CH_COMMA;
		char_q.push_back(c);
		c.out_char = CH_ZERO + {4'd0, len};
		char_q.push_back(c);
		c.out_char = CH_CLOSE;
		c.end_of_text = last;
		char_q.push_back(c);
	endtask

	// Advance the run state by one accepted byte and predict the text it
	// releases: nothing, one tuple or two.
	task automatic encode_byte(input logic [7:0] sym, input logic fin);
		if (run_open && sym == run_sym && run_len < MAX_RUN) begin
			run_len = run_len + 4'd1;
		end else begin
			// A different byte, or a tenth equal one, closes the open run.
			if (run_open)
				queue_tuple(run_sym, run_len, 1'b0);
			run_sym  = sym;
			run_len  = 4'd1;
			run_open = 1'b1;
		end
		if (fin) begin
			// The final byte has joined its run; flush it and start afresh.
			queue_tuple(run_sym, run_len, 1'b1);
			run_sym  = 8'd0;
			run_len  = 4'd0;
			run_open = 1'b0;
		end
	endtask

	task automatic add_byte(input logic [7:0] sym, input logic fin, input logic drain);
		raw_byte_t b;
		b.symbol      = sym;
		b.is_final    = fin;
		b.drain_first = drain;
		byte_q.push_back(b);
	endtask

	// Driver. The byte on the bus is held until it is taken; the next one is
	// offered in the same edge that the current one is accepted, so valid never
	// drops between back-to-back beats.
	always @(posedge clk or negedge arst_n) begin
		raw_byte_t nxt;
		if (!arst_n) begin
			raw.valid    <= 1'b0;
			raw.symbol   <= 8'd0;
			raw.is_final <= 1'b0;
			calm         <= 1'b0;
		end else begin
			if (raw.valid && raw.ready) begin
				encode_byte(raw.symbol, raw.is_final);
				bytes_sent = bytes_sent + 1;
			end
			// A stretch in the middle of the run goes with no gaps on either side.
			calm <= (bytes_sent >= 120 && bytes_sent < 200);
			if (raw.valid && !raw.ready) begin
				// Still waiting for the block to take the current beat.
			end else if (byte_q.size() == 0) begin
				raw.valid <= 1'b0;
			end else if (byte_q[0].drain_first && char_q.size() != 0) begin
				raw.valid <= 1'b0;
			end else if (!calm && $urandom_range(99) < 9) begin
				raw.valid <= 1'b0;
			end else begin
				nxt = byte_q.pop_front();
				raw.valid    <= 1'b1;
				raw.symbol   <= nxt.symbol;
				raw.is_final <= nxt.is_final;
			end
		end
	end

	// Monitor. Every character taken from the block is matched against the
	// oldest prediction, field by field; ready stalls at random outside the
	// calm stretch.
	always @(posedge clk or negedge arst_n) begin
		coded_char_t want;
		if (!arst_n) begin
			coded.ready <= 1'b0;
		end else begin
			if (coded.valid && coded.ready) begin
				if (char_q.size() == 0) begin
					$error("unexpected character: out_char %h end_of_text %b",
						coded.out_char, coded.end_of_text);
					errors = errors + 1;
				end else begin
					want = char_q.pop_front();
					if (coded.out_char !== want.out_char) begin
						$error("out_char: expected %h, got %h", want.out_char,
							coded.out_char);
						errors = errors + 1;
					end
					if (coded.end_of_text !== want.end_of_text) begin
						$error("end_of_text: expected %b, got %b", want.end_of_text,
							coded.end_of_text);
						errors = errors + 1;
					end
				end
			end
			coded.ready <= calm ? 1'b1 : ($urandom_range(99) >= 9);
		end
	end

	// Watchdog: a long spell with no beat on either side means the block hangs.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((raw.valid && raw.ready) || (coded.valid && coded.ready))
				quiet_cycles = 0;
			else
				quiet_cycles = quiet_cycles + 1;
			if (quiet_cycles == STALL_LIMIT) begin
				$display("[rle_ascii_tuple_encoder_core] ERROR");
				$finish;
			end
		end
	end

	initial begin
		int unsigned runs;
		int unsigned len;
		logic [7:0] sym;

		// Every input is known from time zero; the clocked blocks take over
		// at the first edge while reset is still low.
		arst_n       = 1'b0;
		raw.valid    = 1'b0;
		raw.symbol   = 8'd0;
		raw.is_final = 1'b0;
		coded.ready  = 1'b0;
		run_sym      = 8'd0;
		run_len      = 4'd0;
		run_open     = 1'b0;
		bytes_sent   = 0;
		errors       = 0;
		quiet_cycles = 0;

		// Directed part. A lone zero byte that is also final, so the very
		// first byte flushes at once and zero is treated as an ordinary symbol.
		add_byte(8'h00, 1'b1, 1'b0);
		// Ten equal bytes: the tenth closes a full nine-byte run and opens a
		// new one, which the final byte then extends to two.
		for (int i = 0; i < 10; i++)
			add_byte(8'hFF, 1'b0, 1'b0);
		add_byte(8'hFF, 1'b1, 1'b0);
		// A final byte that differs from the open run releases two tuples in
		// one beat; the symbols look like the bracket characters themselves.
		add_byte(CH_OPEN, 1'b0, 1'b0);
		add_byte(CH_CLOSE, 1'b1, 1'b0);
		// Exactly nine equal bytes ending on the final one.
		for (int i = 0; i < 8; i++)
			add_byte(8'h00, 1'b0, 1'b0);
		add_byte(8'h00, 1'b1, 1'b0);

		// Random part. Most of it is whole lines of runs of random length, some
		// longer than nine; the rest is loose bytes with a random final flag.
		// The sender drains the block completely once at the start of this
		// part and once more further on.
		while (byte_q.size() < 23 + RANDOM_BYTES) begin
			if ($urandom_range(99) < 80) begin
				runs = $urandom_range(6, 1);
				for (int r = 0; r < runs; r++) begin
					sym = $urandom_range(255);
					len = ($urandom_range(3) == 0) ? $urandom_range(12, 8)
						: $urandom_range(4, 1);
					for (int k = 0; k < len; k++)
						add_byte(sym, (r == runs - 1) && (k == len - 1),
							(byte_q.size() == 23) || (byte_q.size() == 220));
				end
			end else begin
				add_byte($urandom_range(255), $urandom_range(1),
					(byte_q.size() == 23) || (byte_q.size() == 220));
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (byte_q.size() != 0 || raw.valid)
			@(posedge clk);
		while (char_q.size() != 0)
			@(posedge clk);
		// Let any stray character show itself before the verdict.
		repeat (SETTLE_TIME) @(posedge clk);

		if (char_q.size() != 0) begin
			$error("%0d predicted characters never arrived", char_q.size());
			errors = errors + 1;
		end
		if (errors == 0) begin
			$display("[rle_ascii_tuple_encoder_core] OK");
		end else begin
			$display("[rle_ascii_tuple_encoder_core] ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
design/rle_pkg.sv
design/rle_in_if.sv
design/rle_out_if.sv
design/rle_front.sv
design/rle_queue.sv
design/rle_back.sv
design/rle_ascii_tuple_encoder_core.sv
verif/rle_ascii_tuple_encoder_core_tb.sv
